>>> rtl/swap_slot_allocator_unit_assert.svh
// Assertion macros for the swap slot allocator.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SWAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define SWAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define SSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante holds -> cons holds in the following cycle
`define SSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ssa_pkg.sv
// Shared types and codes for the swap slot allocator.
// No dependencies; imported by swap_slot_allocator_unit, its checker and testbench.
package ssa_pkg;

   localparam int SLOTS_DEFAULT = 1024;

   localparam int CMD_W   = 2;
   localparam int SLOT_W  = 10;
   localparam int VER_W   = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 10;

   localparam logic [CMD_W-1:0] CMD_SWAP_OUT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SWAP_IN  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE     = 2'd2;

   localparam logic [STAT_W-1:0] RSP_OK      = 2'd0;
   localparam logic [STAT_W-1:0] RSP_NOSPACE = 2'd1;
   localparam logic [STAT_W-1:0] RSP_BAD     = 2'd2;

   localparam logic [1:0] SLOT_INVALID = 2'd0;
   localparam logic [1:0] SLOT_FREE    = 2'd1;
   localparam logic [1:0] SLOT_SWAPPED = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_HEAD,
      S_UNLINK,
      S_APPEND,
      S_LINK_TAIL
   } ssa_state_type;

endpackage

>>> rtl/swap_slot_allocator_unit.sv
// Swap slot allocator: free slots on a doubly linked FIFO held in block memories.
// Depends on ssa_pkg and swap_slot_allocator_unit_assert.svh.
//
// After reset the block sweeps every slot of its memories with busy high before
// the first command is taken. A command is taken when start is high and busy low;
// its result word appears on the rsp_ ports for one cycle with rsp_valid, and busy
// is already low in that cycle. A rejected command is answered from the lookup
// state; a swap out of a named free slot then unlinks it, a swap out from the list
// head first reads the head and then unlinks it, and a swap in or a free appends
// the slot and then links the old tail. Slot memory reads are registered.
module swap_slot_allocator_unit #(
   parameter int SLOTS = ssa_pkg::SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ssa_pkg::CMD_W-1:0]    req_command,
   input  logic [ssa_pkg::SLOT_W-1:0]   req_slot,
   input  logic [ssa_pkg::VER_W-1:0]    req_version_in,
   output logic                         rsp_valid,
   output logic [ssa_pkg::STAT_W-1:0]   rsp_status,
   output logic [ssa_pkg::SLOT_W-1:0]   rsp_slot_out,
   output logic [ssa_pkg::VER_W-1:0]    rsp_version_out,
   output logic [ssa_pkg::COUNT_W-1:0]  rsp_free_count
);
   import ssa_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam logic [16:0] SlotLim = 17'(SLOTS);
   localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

   logic [IW-1:0] next_mem [SLOTS];
   logic [IW-1:0] prev_mem [SLOTS];
   logic [VER_W-1:0] ver_mem [SLOTS];
   logic [1:0] stat_mem [SLOTS];

   ssa_state_type state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [VER_W-1:0] ver_ff, ver_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] free_ff, free_in;
   logic [IW-1:0] vic_ff, vic_in;
   logic [IW-1:0] vnext_ff, vnext_in;
   logic [IW-1:0] vprev_ff, vprev_in;
   logic [VER_W-1:0] vver_ff, vver_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [VER_W-1:0] rsp_ver_ff, rsp_ver_in;
   logic [COUNT_W-1:0] rsp_free_ff, rsp_free_in;

   logic [IW-1:0] next_rd_ff, prev_rd_ff;
   logic [VER_W-1:0] ver_rd_ff;
   logic [1:0] stat_rd_ff;

   logic [IW-1:0] rd_addr;
   logic nx_we, pv_we, vr_we, st_we;
   logic [IW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, vr_wa, st_wa;
   logic [VER_W-1:0] vr_wd;
   logic [1:0] st_wd;

   logic accept, slot_ok, req_ok;
   logic [IW-1:0] slot_idx;

   assign accept   = start && (state_ff == S_IDLE);
   assign slot_ok  = 17'(slot_ff) < SlotLim;
   assign req_ok   = 17'(req_slot) < SlotLim;
   assign slot_idx = IW'(slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         head_ff      <= IW'(1);
         tail_ff      <= LastIdx;
         free_ff      <= LastIdx;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      ver_ff        <= ver_in;
      vic_ff        <= vic_in;
      vnext_ff      <= vnext_in;
      vprev_ff      <= vprev_in;
      vver_ff       <= vver_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_ver_ff    <= rsp_ver_in;
      rsp_free_ff   <= rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (nx_we) begin
         next_mem[nx_wa] <= nx_wd;
      end
      next_rd_ff <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pv_we) begin
         prev_mem[pv_wa] <= pv_wd;
      end
      prev_rd_ff <= prev_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (vr_we) begin
         ver_mem[vr_wa] <= vr_wd;
      end
      ver_rd_ff <= ver_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stat_mem[st_wa] <= st_wd;
      end
      stat_rd_ff <= stat_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      ver_in        = ver_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      vic_in        = vic_ff;
      vnext_in      = vnext_ff;
      vprev_in      = vprev_ff;
      vver_in       = vver_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_ver_in    = rsp_ver_ff;
      rsp_free_in   = rsp_free_ff;
      rd_addr       = '0;
      nx_we = 1'b0;  nx_wa = '0;  nx_wd = '0;
      pv_we = 1'b0;  pv_wa = '0;  pv_wd = '0;
      vr_we = 1'b0;  vr_wa = '0;  vr_wd = '0;
      st_we = 1'b0;  st_wa = '0;  st_wd = SLOT_INVALID;

      unique case (state_ff)
         S_CLEAR: begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            vr_we = 1'b1;
            st_we = 1'b1;
            nx_wa = cnt_ff;
            pv_wa = cnt_ff;
            vr_wa = cnt_ff;
            st_wa = cnt_ff;
            nx_wd = (cnt_ff == '0 || cnt_ff == LastIdx) ? '0 : cnt_ff + IW'(1);
            pv_wd = (cnt_ff > IW'(1)) ? cnt_ff - IW'(1) : '0;
            vr_wd = (cnt_ff == '0) ? '0 : VER_W'(1);
            st_wd = (cnt_ff == '0) ? SLOT_INVALID : SLOT_FREE;
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == LastIdx) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = req_ok ? IW'(req_slot) : '0;
            if (start) begin
               cmd_in   = req_command;
               slot_in  = req_slot;
               ver_in   = req_version_in;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            rd_addr       = head_ff;
            rsp_slot_in   = slot_ff;
            rsp_ver_in    = '0;
            rsp_free_in   = COUNT_W'(free_ff);
            rsp_status_in = RSP_BAD;
            unique case (cmd_ff)
               CMD_SWAP_OUT: begin
                  priority if (!slot_ok) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else if (slot_ff != '0 && ver_ff != '0 && ver_rd_ff == ver_ff) begin
                     if (stat_rd_ff != SLOT_FREE) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_IDLE;
                     end else begin
                        vic_in   = slot_idx;
                        vnext_in = next_rd_ff;
                        vprev_in = prev_rd_ff;
                        vver_in  = ver_rd_ff;
                        state_in = S_UNLINK;
                     end
                  end else if (head_ff == '0) begin
                     rsp_status_in = RSP_NOSPACE;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_HEAD;
                  end
               end
               CMD_SWAP_IN, CMD_FREE: begin
                  if (slot_ff == '0 || !slot_ok || stat_rd_ff != SLOT_SWAPPED) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     vic_in   = slot_idx;
                     vver_in  = ver_rd_ff + VER_W'(cmd_ff == CMD_SWAP_IN);
                     state_in = S_APPEND;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_HEAD: begin
            vic_in   = head_ff;
            vnext_in = next_rd_ff;
            vprev_in = prev_rd_ff;
            vver_in  = ver_rd_ff;
            state_in = S_UNLINK;
         end
         S_UNLINK: begin
            if (vprev_ff != '0) begin
               nx_we = 1'b1;
               nx_wa = vprev_ff;
               nx_wd = vnext_ff;
            end else begin
               head_in = vnext_ff;
            end
            if (vnext_ff != '0) begin
               pv_we = 1'b1;
               pv_wa = vnext_ff;
               pv_wd = vprev_ff;
            end else begin
               tail_in = vprev_ff;
            end
            st_we = 1'b1;
            st_wa = vic_ff;
            st_wd = SLOT_SWAPPED;
            vr_we = 1'b1;
            vr_wa = vic_ff;
            vr_wd = vver_ff + VER_W'(2);
            free_in       = free_ff - IW'(free_ff != '0);
            rsp_status_in = RSP_OK;
            rsp_slot_in   = SLOT_W'(vic_ff);
            rsp_ver_in    = vver_ff + VER_W'(2);
            rsp_free_in   = COUNT_W'(free_in);
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         S_APPEND: begin
            nx_we = 1'b1;
            nx_wa = vic_ff;
            nx_wd = '0;
            pv_we = 1'b1;
            pv_wa = vic_ff;
            pv_wd = tail_ff;
            st_we = 1'b1;
            st_wa = vic_ff;
            st_wd = SLOT_FREE;
            vr_we = 1'b1;
            vr_wa = vic_ff;
            vr_wd = vver_ff;
            state_in = S_LINK_TAIL;
         end
         S_LINK_TAIL: begin
            if (tail_ff != '0) begin
               nx_we = 1'b1;
               nx_wa = tail_ff;
               nx_wd = vic_ff;
            end
            if (head_ff == '0) begin
               head_in = vic_ff;
            end
            tail_in       = vic_ff;
            free_in       = free_ff + IW'(1);
            rsp_status_in = RSP_OK;
            rsp_slot_in   = slot_ff;
            rsp_ver_in    = vver_ff;
            rsp_free_in   = COUNT_W'(free_in);
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_version_out = rsp_ver_ff;
   assign rsp_free_count  = rsp_free_ff;

`include "swap_slot_allocator_unit_assert.svh"

   `SSA_ASSERT_NEXT(a_word_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobe held two cycles")
   `SSA_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_valid_ff, "accepted word did not start work")
   `SSA_ASSERT_SAME(a_empty_ends, clock, reset, state_ff != S_CLEAR, (head_ff == '0) == (tail_ff == '0), "list head and tail disagree on empty")
   `SSA_ASSERT_SAME(a_empty_count, clock, reset, state_ff != S_CLEAR && head_ff == '0, free_ff == '0, "empty list with nonzero free count")
   `SSA_ASSERT_SAME(a_count_max, clock, reset, 1'b1, free_ff <= LastIdx, "free count above slot capacity")

endmodule

>>> tb/sv/swap_slot_allocator_unit_checker.sv
`timescale 1ns / 1ps
// Checker for swap_slot_allocator_unit: keeps its own free-slot list, versions and slot
// states, predicts each result word at command accept and compares it on rsp_valid.
// Depends on ssa_pkg.
module swap_slot_allocator_unit_checker #(
   parameter int SLOTS = ssa_pkg::SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [ssa_pkg::CMD_W-1:0]    req_command,
   input  logic [ssa_pkg::SLOT_W-1:0]   req_slot,
   input  logic [ssa_pkg::VER_W-1:0]    req_version_in,
   input  logic                         rsp_valid,
   input  logic [ssa_pkg::STAT_W-1:0]   rsp_status,
   input  logic [ssa_pkg::SLOT_W-1:0]   rsp_slot_out,
   input  logic [ssa_pkg::VER_W-1:0]    rsp_version_out,
   input  logic [ssa_pkg::COUNT_W-1:0]  rsp_free_count,
   output int                           fail_count,
   output int                           outstanding
);
   import ssa_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [SLOT_W-1:0]  slot_out;
      logic [VER_W-1:0]   version_out;
      logic [COUNT_W-1:0] free_count;
   } alloc_word_type;

   logic [SLOT_W-1:0] link_next  [SLOTS];
   logic [SLOT_W-1:0] link_prev  [SLOTS];
   logic [VER_W-1:0]  version_of [SLOTS];
   logic [1:0]        state_of   [SLOTS];
   int                head_slot;
   int                tail_slot;
   int                free_total;
   alloc_word_type    expected_words[$];

   function automatic void clear_list();
      for (int i = 0; i < SLOTS; i++) begin
         link_next[i]  = (i > 0 && i + 1 < SLOTS) ? SLOT_W'(i + 1) : '0;
         link_prev[i]  = (i > 1) ? SLOT_W'(i - 1) : '0;
         version_of[i] = (i == 0) ? '0 : VER_W'(1);
         state_of[i]   = (i == 0) ? SLOT_INVALID : SLOT_FREE;
      end
      head_slot  = 1;
      tail_slot  = SLOTS - 1;
      free_total = SLOTS - 1;
   endfunction

   function automatic void unlink_free(int s);
      int p;
      int n;
      p = int'(link_prev[s]);
      n = int'(link_next[s]);
      if (p != 0) link_next[p] = SLOT_W'(n);
      else head_slot = n;
      if (n != 0) link_prev[n] = SLOT_W'(p);
      else tail_slot = p;
      if (free_total > 0) free_total--;
      link_next[s]  = '0;
      link_prev[s]  = '0;
      state_of[s]   = SLOT_SWAPPED;
      version_of[s] = version_of[s] + 1;
   endfunction

   function automatic void append_tail(int s);
      link_prev[s] = SLOT_W'(tail_slot);
      link_next[s] = '0;
      if (tail_slot != 0) link_next[tail_slot] = SLOT_W'(s);
      tail_slot = s;
      if (head_slot == 0) head_slot = s;
      free_total++;
      state_of[s] = SLOT_FREE;
   endfunction

   function automatic alloc_word_type allocate_word(logic [CMD_W-1:0] cmd,
                                                    logic [SLOT_W-1:0] slot,
                                                    logic [VER_W-1:0] ver);
      alloc_word_type w;
      int s;
      int h;
      s = int'(slot);
      w.status      = RSP_OK;
      w.slot_out    = slot;
      w.version_out = '0;
      if (cmd == CMD_SWAP_OUT) begin
         if (s >= SLOTS) begin
            w.status = RSP_BAD;
         end else if (s != 0 && ver != 0 && version_of[s] == ver) begin
            if (state_of[s] != SLOT_FREE) begin
               w.status = RSP_BAD;
            end else begin
               unlink_free(s);
               version_of[s] = version_of[s] + 1;
               w.version_out = version_of[s];
            end
         end else if (head_slot == 0 || head_slot >= SLOTS) begin
            w.status = RSP_NOSPACE;
         end else begin
            h = head_slot;
            unlink_free(h);
            version_of[h] = version_of[h] + 1;
            w.slot_out    = SLOT_W'(h);
            w.version_out = version_of[h];
         end
      end else if (cmd == CMD_SWAP_IN || cmd == CMD_FREE) begin
         if (s == 0 || s >= SLOTS || state_of[s] != SLOT_SWAPPED) begin
            w.status = RSP_BAD;
         end else begin
            if (cmd == CMD_SWAP_IN) version_of[s] = version_of[s] + 1;
            append_tail(s);
            w.version_out = version_of[s];
         end
      end else begin
         w.status = RSP_BAD;
      end
      w.free_count = COUNT_W'(free_total);
      return w;
   endfunction

   function automatic void check_field(string name, logic [VER_W-1:0] want,
                                       logic [VER_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      alloc_word_type want;
      if (reset) begin
         clear_list();
         expected_words.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               $error("result word with none expected: slot_out %0d", rsp_slot_out);
            end else begin
               want = expected_words.pop_front();
               check_field("status", VER_W'(want.status), VER_W'(rsp_status));
               check_field("slot_out", VER_W'(want.slot_out), VER_W'(rsp_slot_out));
               check_field("version_out", want.version_out, rsp_version_out);
               check_field("free_count", VER_W'(want.free_count), VER_W'(rsp_free_count));
            end
         end
         if (start && !busy)
            expected_words.push_back(allocate_word(req_command, req_slot, req_version_in));
      end
      outstanding <= expected_words.size();
   end

endmodule

>>> tb/sv/swap_slot_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Top of the swap_slot_allocator_unit testbench: clock, reset and command stimulus
// (directed, list drain to empty, random mix); verdict from the checker's counts.
// Depends on ssa_pkg, swap_slot_allocator_unit and swap_slot_allocator_unit_checker.
module swap_slot_allocator_unit_tb;
   import ssa_pkg::*;

   localparam int SLOTS       = SLOTS_DEFAULT;
   localparam int STALL_LIMIT = 8000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_command;
   logic [SLOT_W-1:0]   req_slot;
   logic [VER_W-1:0]    req_version_in;
   logic                rsp_valid;
   logic [STAT_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic [VER_W-1:0]    rsp_version_out;
   logic [COUNT_W-1:0]  rsp_free_count;
   int                  fail_count;
   int                  outstanding;

   logic [CMD_W-1:0]    cmds_in_flight[$];
   logic [SLOT_W-1:0]   held_slots[$];
   logic [SLOT_W-1:0]   known_slots[$];
   logic [VER_W-1:0]    known_versions[$];
   int                  nospace_seen;
   int                  quiet_cycles;
   int                  idle_pct;

   swap_slot_allocator_unit #(.SLOTS(SLOTS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_slot(req_slot), .req_version_in(req_version_in),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_slot_out(rsp_slot_out),
      .rsp_version_out(rsp_version_out), .rsp_free_count(rsp_free_count)
   );

   swap_slot_allocator_unit_checker #(.SLOTS(SLOTS)) i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_slot(req_slot), .req_version_in(req_version_in),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_slot_out(rsp_slot_out),
      .rsp_version_out(rsp_version_out), .rsp_free_count(rsp_free_count),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // slot pools for well-formed sequences, fed from result words
   always @(posedge clock) begin : track
      logic [CMD_W-1:0] c;
      if (!reset) begin
         if (rsp_valid && cmds_in_flight.size() != 0) begin
            c = cmds_in_flight.pop_front();
            if (rsp_status == RSP_NOSPACE) nospace_seen++;
            if (rsp_status == RSP_OK && c == CMD_SWAP_OUT) begin
               held_slots.push_back(rsp_slot_out);
            end else if (rsp_status == RSP_OK && c == CMD_SWAP_IN) begin
               known_slots.push_back(rsp_slot_out);
               known_versions.push_back(rsp_version_out);
            end
         end
         if (start && !busy) cmds_in_flight.push_back(req_command);
      end
      if ((start && !busy) || rsp_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_word(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                            logic [VER_W-1:0] ver);
      start          = 1'b1;
      req_command    = cmd;
      req_slot       = slot;
      req_version_in = ver;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic pause(int pct);
      if ($urandom_range(0, 99) < pct) begin
         start          = 1'b0;
         req_command    = CMD_W'($urandom);
         req_slot       = SLOT_W'($urandom);
         req_version_in = $urandom;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   task automatic wait_all_results();
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic fresh_swap_out();
      case ($urandom_range(0, 2))
         0: send_word(CMD_SWAP_OUT, '0, $urandom);
         1: send_word(CMD_SWAP_OUT, SLOT_W'($urandom_range(1, SLOTS - 1)), '0);
         default: send_word(CMD_SWAP_OUT, '0, '0);
      endcase
   endtask

   task automatic noise_word();
      logic [CMD_W-1:0] cmd;
      logic [VER_W-1:0] ver;
      cmd = CMD_W'($urandom);
      case ($urandom_range(0, 2))
         0: ver = $urandom_range(0, 4);
         1: ver = $urandom;
         default: ver = '0;
      endcase
      send_word(cmd, SLOT_W'($urandom), ver);
   endtask

   task automatic mixed_word();
      int r;
      int k;
      logic [SLOT_W-1:0] s;
      logic [VER_W-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         fresh_swap_out();
      end else if (r < 55 && held_slots.size() != 0) begin
         k = $urandom_range(0, held_slots.size() - 1);
         s = held_slots[k];
         held_slots.delete(k);
         send_word((r < 43) ? CMD_SWAP_IN : CMD_FREE, s, $urandom);
      end else if (r < 75 && known_slots.size() != 0) begin
         k = $urandom_range(0, known_slots.size() - 1);
         s = known_slots[k];
         v = known_versions[k];
         if ($urandom_range(0, 3) == 0) v = v + $urandom_range(1, 2);
         if ($urandom_range(0, 1) == 0) begin
            known_slots.delete(k);
            known_versions.delete(k);
         end
         send_word(CMD_SWAP_OUT, s, v);
      end else begin
         noise_word();
      end
   endtask

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 10;
         default: return 35;
      endcase
   endfunction

   initial begin : stimulus
      int n;
      reset          = 1'b1;
      start          = 1'b0;
      req_command    = CMD_SWAP_OUT;
      req_slot       = '0;
      req_version_in = '0;
      nospace_seen   = 0;
      quiet_cycles   = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(CMD_UNUSED, '0, '0);
      send_word(CMD_UNUSED, '1, '1);
      send_word(CMD_SWAP_IN, '0, '0);
      send_word(CMD_FREE, 10'd5, '0);             // free slot not swapped out
      send_word(CMD_SWAP_OUT, '0, '0);            // head
      send_word(CMD_SWAP_OUT, '1, 32'd1);         // named tail slot
      send_word(CMD_SWAP_OUT, '1, 32'd3);         // version match, not free
      send_word(CMD_SWAP_OUT, '0, '1);
      send_word(CMD_SWAP_OUT, 10'd7, '0);
      send_word(CMD_SWAP_OUT, 10'd9, '1);         // version mismatch
      send_word(CMD_SWAP_OUT, 10'd500, 32'd1);    // named middle slot
      send_word(CMD_SWAP_OUT, 10'd5, 32'd1);      // named head slot
      send_word(CMD_SWAP_IN, 10'd1, '0);
      send_word(CMD_FREE, '1, '0);
      send_word(CMD_SWAP_IN, '1, '0);
      send_word(CMD_SWAP_OUT, 10'd1, 32'd4);
      send_word(CMD_SWAP_OUT, '1, 32'd3);
      send_word(CMD_FREE, 10'd500, '0);
      send_word(CMD_FREE, 10'd500, '0);
      send_word(CMD_SWAP_IN, 10'd2, '0);
      send_word(CMD_FREE, 10'd3, '0);
      wait_all_results();

      for (int i = 0; i < 60; i++) begin
         if (i % 50 == 0) idle_pct = pick_idle_pct();
         pause(idle_pct);
         mixed_word();
      end

      // run the list dry and keep asking
      n = 0;
      while (nospace_seen < 5 && n < 1400) begin
         pause(5);
         if ($urandom_range(0, 9) == 0) noise_word();
         else fresh_swap_out();
         n++;
      end
      wait_all_results();

      for (int i = 0; i < 100; i++) begin
         if (i % 50 == 0) idle_pct = pick_idle_pct();
         if (i >= 75) idle_pct = 0;
         if (i < 75 && $urandom_range(0, 99) == 0) wait_all_results();
         pause(idle_pct);
         mixed_word();
      end

      wait_all_results();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/ssa_pkg.sv
rtl/swap_slot_allocator_unit.sv
tb/sv/swap_slot_allocator_unit_checker.sv
tb/sv/swap_slot_allocator_unit_tb.sv
